@@ sv/dka_pkg.sv @@
package dka_pkg;

	localparam int REG_W  = 8;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_REPEAT  = 2'd2,
		EV_REFRESH = 2'd3
	} ev_kind_t;

	typedef enum logic [2:0] {
		REG_RELEASE_DELAY  = 3'd0,
		REG_AUTOREPEAT_EN  = 3'd1,
		REG_INITIAL_DELAY  = 3'd2,
		REG_REPEAT_PERIOD  = 3'd3,
		REG_REFRESH_EN     = 3'd4,
		REG_REFRESH_PERIOD = 3'd5
	} reg_idx_t;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic [REG_W-1:0] RST_RELEASE_DELAY  = 8'd5;
	localparam logic [REG_W-1:0] RST_INITIAL_DELAY  = 8'd50;
	localparam logic [REG_W-1:0] RST_REPEAT_PERIOD  = 8'd10;
	localparam logic [REG_W-1:0] RST_REFRESH_PERIOD = 8'd10;

	typedef struct packed {
		logic [REG_W-1:0] release_delay;
		logic             autorepeat_enable;
		logic [REG_W-1:0] initial_delay;
		logic [REG_W-1:0] repeat_period;
		logic             refresh_enable;
		logic [REG_W-1:0] refresh_period;
	} cfg_t;

endpackage

@@ sv/dka_ifs.sv @@
interface key_in_if #(parameter int NUM_KEYS = 4);
	logic                valid;
	logic                ready;
	logic                func;
	logic [NUM_KEYS-1:0] pins_low;

	modport source (output valid, func, pins_low, input ready);
	modport sink (input valid, func, pins_low, output ready);
endinterface

interface key_evt_if #(parameter int NUM_KEYS = 4);
	logic                valid;
	logic                ready;
	logic [1:0]          event_kind;
	logic [NUM_KEYS-1:0] keys_held;
	logic                last;

	modport source (output valid, event_kind, keys_held, last, input ready);
	modport sink (input valid, event_kind, keys_held, last, output ready);
endinterface

@@ sv/dka_cfg.sv @@
module dka_cfg
	import dka_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.release_delay     <= RST_RELEASE_DELAY;
			cfg_q.autorepeat_enable <= 1'b0;
			cfg_q.initial_delay     <= RST_INITIAL_DELAY;
			cfg_q.repeat_period     <= RST_REPEAT_PERIOD;
			cfg_q.refresh_enable    <= 1'b0;
			cfg_q.refresh_period    <= RST_REFRESH_PERIOD;
		end else if (wr) begin
			case (idx)
				REG_RELEASE_DELAY:  cfg_q.release_delay     <= pwdata[REG_W-1:0];
				REG_AUTOREPEAT_EN:  cfg_q.autorepeat_enable <= pwdata[0];
				REG_INITIAL_DELAY:  cfg_q.initial_delay     <= pwdata[REG_W-1:0];
				REG_REPEAT_PERIOD:  cfg_q.repeat_period     <= pwdata[REG_W-1:0];
				REG_REFRESH_EN:     cfg_q.refresh_enable    <= pwdata[0];
				REG_REFRESH_PERIOD: cfg_q.refresh_period    <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RELEASE_DELAY:  prdata = DATA_W'(cfg_q.release_delay);
			REG_AUTOREPEAT_EN:  prdata = DATA_W'(cfg_q.autorepeat_enable);
			REG_INITIAL_DELAY:  prdata = DATA_W'(cfg_q.initial_delay);
			REG_REPEAT_PERIOD:  prdata = DATA_W'(cfg_q.repeat_period);
			REG_REFRESH_EN:     prdata = DATA_W'(cfg_q.refresh_enable);
			REG_REFRESH_PERIOD: prdata = DATA_W'(cfg_q.refresh_period);
			default:            prdata = '0;
		endcase
	end

endmodule

@@ sv/dka_front.sv @@
module dka_front
	import dka_pkg::*;
#(
	parameter int NUM_KEYS   = 4,
	parameter int COUNT_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	key_in_if.sink              keys,
	input  cfg_t                cfg,
	input  logic                full,
	output logic                push,
	output logic                push_func,
	output logic [NUM_KEYS-1:0] push_mask,
	output logic [NUM_KEYS-1:0] push_flags,
	output logic                push_rep,
	output logic                push_ref
);

	localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

	logic [NUM_KEYS-1:0]   held_q, held_n;
	logic [COUNT_BITS-1:0] cd_q [NUM_KEYS];
	logic [COUNT_BITS-1:0] cd_n [NUM_KEYS];
	logic                  armed_q, armed_n;
	logic [COUNT_BITS-1:0] rc_q, rc_n, rc_dec;
	logic [COUNT_BITS-1:0] rf_q, rf_n, rf_inc;
	logic [CMP_W-1:0]      rf_cmp;
	logic [NUM_KEYS-1:0]   flags, pressed;
	logic                  rep, rfe, acc;

	assign keys.ready = !full;
	assign acc        = keys.valid && !full;
	assign pressed    = ~keys.pins_low;

	always_comb begin
		held_n  = held_q;
		cd_n    = cd_q;
		armed_n = armed_q;
		rc_n    = rc_q;
		rf_n    = rf_q;
		flags   = '0;
		rep     = 1'b0;
		rfe     = 1'b0;
		rc_dec  = rc_q - 1'b1;
		rf_inc  = rf_q + 1'b1;
		rf_cmp  = CMP_W'(rf_inc);
		if (keys.func == FUNC_SAMPLE) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (pressed[i] != held_q[i]) begin
					if (!held_q[i]) begin
						held_n[i] = 1'b1;
						cd_n[i]   = '0;
						flags[i]  = 1'b1;
					end else begin
						cd_n[i] = COUNT_BITS'(cfg.release_delay);
					end
				end else begin
					cd_n[i] = '0;
				end
			end
			if ((|flags) && cfg.autorepeat_enable) begin
				armed_n = 1'b1;
				rc_n    = COUNT_BITS'(cfg.initial_delay);
			end
		end else begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (cd_q[i] != '0) begin
					cd_n[i] = cd_q[i] - 1'b1;
					if (cd_q[i] == COUNT_BITS'(1)) begin
						held_n[i] = 1'b0;
						flags[i]  = 1'b1;
					end
				end
			end
			// any release drops autorepeat before the repeat timer runs
			if (|flags)
				armed_n = 1'b0;
			if (armed_n && cfg.autorepeat_enable) begin
				if (rc_dec == '0) begin
					rc_n = COUNT_BITS'(cfg.repeat_period);
					rep  = 1'b1;
				end else begin
					rc_n = rc_dec;
				end
			end
			if (cfg.refresh_enable) begin
				if (rf_cmp >= CMP_W'(cfg.refresh_period)) begin
					rf_n = '0;
					rfe  = 1'b1;
				end else begin
					rf_n = rf_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			armed_q <= 1'b0;
			rc_q    <= '0;
			rf_q    <= '0;
			for (int i = 0; i < NUM_KEYS; i++)
				cd_q[i] <= '0;
		end else if (acc) begin
			held_q  <= held_n;
			armed_q <= armed_n;
			rc_q    <= rc_n;
			rf_q    <= rf_n;
			cd_q    <= cd_n;
		end
	end

	// mask before the word is what the back end starts its walk from
	assign push       = acc && ((|flags) || rep || rfe);
	assign push_func  = keys.func;
	assign push_mask  = held_q;
	assign push_flags = flags;
	assign push_rep   = rep;
	assign push_ref   = rfe;

	a_release_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		acc && keys.func == FUNC_TICK && (|flags) |=> !armed_q)
		else $error("release did not disarm autorepeat");

	a_held_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && keys.func == FUNC_SAMPLE |=> ((held_q & ~$past(held_q)) == $past(flags)))
		else $error("held mask change does not match press flags");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push while queue full");

endmodule

@@ sv/dka_queue.sv @@
module dka_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");

endmodule

@@ sv/dka_back.sv @@
module dka_back
	import dka_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  logic                word_func,
	input  logic [NUM_KEYS-1:0] word_mask,
	input  logic [NUM_KEYS-1:0] word_flags,
	input  logic                word_rep,
	input  logic                word_ref,
	output logic                pop,
	key_evt_if.source           events
);

	logic                busy_q, rel_q, rep_q, ref_q;
	logic [NUM_KEYS-1:0] mask_q, flags_q, low, rem;
	logic                is_key, last, fire;
	ev_kind_t            kind;

	assign low    = flags_q & (~flags_q + 1'b1);
	assign rem    = flags_q & ~low;
	assign is_key = |flags_q;
	assign fire   = busy_q && events.ready;

	always_comb begin
		if (is_key) begin
			kind = rel_q ? EV_RELEASE : EV_PRESS;
			last = (rem == '0) && !rep_q && !ref_q;
		end else if (rep_q) begin
			kind = EV_REPEAT;
			last = !ref_q;
		end else begin
			kind = EV_REFRESH;
			last = 1'b1;
		end
	end

	assign events.valid      = busy_q;
	assign events.event_kind = kind;
	assign events.keys_held  = mask_q ^ low;
	assign events.last       = last;

	assign pop = !empty && (!busy_q || (fire && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rel_q   <= 1'b0;
			rep_q   <= 1'b0;
			ref_q   <= 1'b0;
			mask_q  <= '0;
			flags_q <= '0;
		end else if (pop) begin
			busy_q  <= 1'b1;
			rel_q   <= (word_func == FUNC_TICK);
			rep_q   <= word_rep;
			ref_q   <= word_ref;
			mask_q  <= word_mask;
			flags_q <= word_flags;
		end else if (fire) begin
			if (last)
				busy_q <= 1'b0;
			if (is_key) begin
				flags_q <= rem;
				mask_q  <= mask_q ^ low;
			end else if (rep_q) begin
				rep_q <= 1'b0;
			end else begin
				ref_q <= 1'b0;
			end
		end
	end

	a_busy_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (is_key || rep_q || ref_q))
		else $error("active word holds no event");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last && empty |=> !busy_q)
		else $error("back end still busy after last event");

endmodule

@@ sv/key_debounce_autorepeat.sv @@
// Four-key (NUM_KEYS) debouncer with autorepeat and a refresh divider.
// keys:   input words, func 0 = pin sample (pins_low active low), 1 = timer tick.
// events: result words, event_kind 0 press, 1 release, 2 repeat, 3 refresh,
//         keys_held = qualified mask after that event, last marks the final
//         event caused by one input word. Words that cause no event give none.
// APB port: six registers at byte address 4*i, writes take effect on the
//   access cycle; write only while no events are outstanding.
// Throughput: the front end takes one input word per cycle while its two-entry
//   queue has room; the back end sends one event per cycle while events.ready is
//   high; a word with k events holds the back end until all k are taken (k up to
//   NUM_KEYS + 1, since a release suppresses the repeat on the same tick).
// With the queue and back end idle, an accepted word is written into the queue and
//   then loaded into the back-end word register, which makes its first event valid.
// Reset clears held keys, countdowns, autorepeat and refresh counters and
//   loads register defaults. A stalled events.ready holds the current event;
//   input is still accepted until the queue fills, then keys.ready drops.
module key_debounce_autorepeat
	import dka_pkg::*;
#(
	parameter int NUM_KEYS   = 4,
	parameter int COUNT_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	key_in_if.sink            keys,
	key_evt_if.source         events,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int WORD_W = 1 + 2 * NUM_KEYS + 2;

	cfg_t                cfg;
	logic                full, empty, push, pop;
	logic                push_func, push_rep, push_ref;
	logic [NUM_KEYS-1:0] push_mask, push_flags;
	logic [WORD_W-1:0]   wdata, rdata;

	dka_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dka_front #(
		.NUM_KEYS   (NUM_KEYS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.keys       (keys),
		.cfg        (cfg),
		.full       (full),
		.push       (push),
		.push_func  (push_func),
		.push_mask  (push_mask),
		.push_flags (push_flags),
		.push_rep   (push_rep),
		.push_ref   (push_ref)
	);

	assign wdata = {push_func, push_mask, push_flags, push_rep, push_ref};

	dka_queue #(
		.WIDTH (WORD_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.full   (full),
		.empty  (empty)
	);

	dka_back #(
		.NUM_KEYS (NUM_KEYS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.word_func  (rdata[WORD_W-1]),
		.word_mask  (rdata[WORD_W-2 -: NUM_KEYS]),
		.word_flags (rdata[NUM_KEYS+1 -: NUM_KEYS]),
		.word_rep   (rdata[1]),
		.word_ref   (rdata[0]),
		.pop        (pop),
		.events     (events)
	);

endmodule
